// File: hw/rtl/lsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Least-squares line fit: shared definitions
// Widths of the running sums, the product and quotient datapaths, and the
// snapshot types that travel from the front end to the fit engine.
// ----------------------------------------------------------------------------
package lsf_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int FRAC_BITS   = 16;
   localparam int X_W         = 16;
   localparam int OUT_W       = 48;

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SX_W   = X_W + CNT_W;
   localparam int SXY_W  = 2 * X_W + CNT_W - 1;
   localparam int OPD_W  = SXY_W;
   localparam int PROD_W = 2 * OPD_W;
   localparam int NUM_W  = PROD_W + 1;
   localparam int DVD_W  = NUM_W + FRAC_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [SXY_W-1:0] sxy;
      logic signed [SX_W-1:0]  sx;
      logic signed [SX_W-1:0]  sy;
      logic signed [SXY_W-1:0] sxx;
   } sums_type;

   typedef struct packed {
      logic     valid;
      sums_type sums;
   } push_type;

   typedef struct packed {
      logic     valid;
      logic     full;
      sums_type head;
   } queue_status_type;

endpackage
`default_nettype wire

// File: hw/rtl/lsf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Least-squares line fit: front end
// Takes one sample pair per beat, keeps the running sums and closes a set on
// the marked pair or on the last allowed pair, pushing the sums to the queue.
// ----------------------------------------------------------------------------
module lsf_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [lsf_pkg::X_W-1:0] req_x_sample,
   input  wire logic signed [lsf_pkg::X_W-1:0] req_y_sample,
   input  wire logic                        req_last_sample,
   input  wire logic                        queue_full,
   output lsf_pkg::push_type                push
);
   import lsf_pkg::*;

   logic                    accept;
   logic                    closing;
   logic signed [2*X_W-1:0] xy_prod;
   logic signed [2*X_W-1:0] xx_prod;
   sums_type                sums_ff;
   sums_type                sums_in;
   sums_type                sums_next;

   assign busy    = queue_full;
   assign accept  = start & ~queue_full;
   assign xy_prod = (2*X_W)'(req_x_sample) * (2*X_W)'(req_y_sample);
   assign xx_prod = (2*X_W)'(req_x_sample) * (2*X_W)'(req_x_sample);

   always_comb begin
      sums_next.count = sums_ff.count + CNT_W'(1);
      sums_next.sxy   = sums_ff.sxy + SXY_W'(xy_prod);
      sums_next.sx    = sums_ff.sx + SX_W'(req_x_sample);
      sums_next.sy    = sums_ff.sy + SX_W'(req_y_sample);
      sums_next.sxx   = sums_ff.sxx + SXY_W'(xx_prod);
      closing = req_last_sample | (sums_next.count == CNT_W'(MAX_SAMPLES));
      sums_in = sums_ff;
      if (accept) begin
         sums_in = closing ? '0 : sums_next;
      end
      push.valid = accept & closing;
      push.sums  = sums_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sums_ff <= '0;
      end else begin
         sums_ff <= sums_in;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/lsf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Least-squares line fit: snapshot queue
// Short first-in first-out store of closed sets between front end and engine.
// ----------------------------------------------------------------------------
module lsf_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lsf_pkg::push_type         push,
   input  wire logic                      pop,
   output lsf_pkg::queue_status_type      status
);
   import lsf_pkg::*;

   sums_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push.valid) begin
         count_in = count_ff - QCNT_W'(1);
      end
      status.valid = (count_ff != '0);
      status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
      status.head  = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entries_ff[wr_ptr_ff] <= push.sums;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/lsf_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Least-squares line fit: sequential multiplier
// Signed shift-add multiplier, one bit of the second operand per cycle.
// ----------------------------------------------------------------------------
module lsf_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [lsf_pkg::OPD_W-1:0] opd_a,
   input  wire logic signed [lsf_pkg::OPD_W-1:0] opd_b,
   output logic                               done,
   output logic signed [lsf_pkg::PROD_W-1:0]  product
);
   import lsf_pkg::*;

   localparam int MCNT_W = $clog2(OPD_W);

   typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mul_state_type;

   mul_state_type     state_ff;
   logic [MCNT_W-1:0] count_ff;
   logic [PROD_W-1:0] a_ff;
   logic [OPD_W-1:0]  b_ff;
   logic [PROD_W-1:0] acc_ff;
   logic              neg_ff;
   logic              done_ff;
   logic [PROD_W-1:0] product_ff;
   logic [OPD_W-1:0]  a_mag;
   logic [OPD_W-1:0]  b_mag;

   assign a_mag   = opd_a[OPD_W-1] ? (~opd_a) + OPD_W'(1) : opd_a;
   assign b_mag   = opd_b[OPD_W-1] ? (~opd_b) + OPD_W'(1) : opd_b;
   assign done    = done_ff;
   assign product = product_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  a_ff     <= PROD_W'(a_mag);
                  b_ff     <= b_mag;
                  acc_ff   <= '0;
                  neg_ff   <= opd_a[OPD_W-1] ^ opd_b[OPD_W-1];
                  count_ff <= '0;
                  state_ff <= M_RUN;
               end
            end
            M_RUN: begin
               if (b_ff[0]) begin
                  acc_ff <= acc_ff + a_ff;
               end
               a_ff     <= a_ff << 1;
               b_ff     <= b_ff >> 1;
               count_ff <= count_ff + MCNT_W'(1);
               if (count_ff == MCNT_W'(OPD_W - 1)) begin
                  state_ff <= M_FIN;
               end
            end
            M_FIN: begin
               product_ff <= neg_ff ? (~acc_ff) + PROD_W'(1) : acc_ff;
               done_ff    <= 1'b1;
               state_ff   <= M_IDLE;
            end
            default: begin
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/lsf_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Least-squares line fit: fixed-point divider
// Restoring divider, one quotient bit per cycle; truncates toward zero and
// saturates to the result width.
// ----------------------------------------------------------------------------
module lsf_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic signed [lsf_pkg::NUM_W-1:0] num,
   input  wire logic [lsf_pkg::NUM_W-1:0]     den,
   output logic                               done,
   output logic signed [lsf_pkg::OUT_W-1:0]   quot
);
   import lsf_pkg::*;

   localparam int DCNT_W = $clog2(DVD_W);
   localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(1) << (OUT_W - 1);
   localparam logic [DVD_W-1:0] POS_LIM = NEG_LIM - DVD_W'(1);

   typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} div_state_type;

   div_state_type     state_ff;
   logic [DCNT_W-1:0] count_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [DVD_W-1:0]  quot_ff;
   logic [NUM_W-1:0]  rem_ff;
   logic [NUM_W-1:0]  den_ff;
   logic              neg_ff;
   logic              done_ff;
   logic [OUT_W-1:0]  result_ff;
   logic [NUM_W-1:0]  num_mag;
   logic [NUM_W-1:0]  rem_sh;
   logic              fits;
   logic              over;
   logic [OUT_W-1:0]  mag_out;

   always_comb begin
      num_mag = num[NUM_W-1] ? (~num) + NUM_W'(1) : num;
      rem_sh  = {rem_ff[NUM_W-2:0], dvd_ff[DVD_W-1]};
      fits    = (rem_sh >= den_ff);
      over    = neg_ff ? (quot_ff > NEG_LIM) : (quot_ff > POS_LIM);
      if (over) begin
         mag_out = neg_ff ? NEG_LIM[OUT_W-1:0] : POS_LIM[OUT_W-1:0];
      end else begin
         mag_out = quot_ff[OUT_W-1:0];
      end
   end

   assign done = done_ff;
   assign quot = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  dvd_ff   <= DVD_W'(num_mag) << FRAC_BITS;
                  den_ff   <= den;
                  neg_ff   <= num[NUM_W-1];
                  rem_ff   <= '0;
                  quot_ff  <= '0;
                  count_ff <= '0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff   <= fits ? rem_sh - den_ff : rem_sh;
               quot_ff  <= {quot_ff[DVD_W-2:0], fits};
               dvd_ff   <= dvd_ff << 1;
               count_ff <= count_ff + DCNT_W'(1);
               if (count_ff == DCNT_W'(DVD_W - 1)) begin
                  state_ff <= D_FIN;
               end
            end
            D_FIN: begin
               result_ff <= neg_ff ? (~mag_out) + OUT_W'(1) : mag_out;
               done_ff   <= 1'b1;
               state_ff  <= D_IDLE;
            end
            default: begin
               state_ff <= D_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/lsf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Least-squares line fit: fit engine
// Pops a closed set, forms the denominator and both numerators on the shared
// multiplier, divides on the shared divider unless degenerate, emits a result.
// ----------------------------------------------------------------------------
module lsf_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lsf_pkg::queue_status_type     queue,
   output logic                               pop,
   output logic                               rsp_strobe,
   output logic signed [lsf_pkg::OUT_W-1:0]   rsp_slope,
   output logic signed [lsf_pkg::OUT_W-1:0]   rsp_intercept,
   output logic                               rsp_degenerate
);
   import lsf_pkg::*;

   typedef enum logic [2:0] {B_IDLE, B_MUL, B_CHECK, B_DIV_S, B_DIV_I} back_state_type;

   typedef enum logic [2:0] {
      P_NSXX, P_SXSX, P_NSXY, P_SXSY, P_SYSXX, P_SXSXY
   } prod_type;

   typedef struct packed {
      logic signed [OPD_W-1:0] a;
      logic signed [OPD_W-1:0] b;
   } opd_pair_type;

   function automatic opd_pair_type operands(input prod_type sel, input sums_type s);
      opd_pair_type r;
      case (sel)
         P_NSXX: begin
            r.a = OPD_W'({1'b0, s.count});
            r.b = OPD_W'(s.sxx);
         end
         P_SXSX: begin
            r.a = OPD_W'(s.sx);
            r.b = OPD_W'(s.sx);
         end
         P_NSXY: begin
            r.a = OPD_W'({1'b0, s.count});
            r.b = OPD_W'(s.sxy);
         end
         P_SXSY: begin
            r.a = OPD_W'(s.sx);
            r.b = OPD_W'(s.sy);
         end
         P_SYSXX: begin
            r.a = OPD_W'(s.sy);
            r.b = OPD_W'(s.sxx);
         end
         P_SXSXY: begin
            r.a = OPD_W'(s.sx);
            r.b = OPD_W'(s.sxy);
         end
         default: begin
            r.a = '0;
            r.b = '0;
         end
      endcase
      return r;
   endfunction

   back_state_type          state_ff;
   prod_type                prod_ff;
   prod_type                prod_next;
   sums_type                snap_ff;
   opd_pair_type            first_ops;
   opd_pair_type            next_ops;
   logic                    mul_start_ff;
   logic signed [OPD_W-1:0] mul_a_ff;
   logic signed [OPD_W-1:0] mul_b_ff;
   logic                    mul_done;
   logic signed [PROD_W-1:0] mul_product;
   logic signed [NUM_W-1:0] prod_ext;
   logic signed [NUM_W-1:0] den_ff;
   logic signed [NUM_W-1:0] sn_ff;
   logic signed [NUM_W-1:0] in_ff;
   logic                    div_start_ff;
   logic signed [NUM_W-1:0] div_num_ff;
   logic                    div_done;
   logic signed [OUT_W-1:0] div_quot;
   logic                    rsp_strobe_ff;
   logic signed [OUT_W-1:0] rsp_slope_ff;
   logic signed [OUT_W-1:0] rsp_intercept_ff;
   logic                    rsp_degenerate_ff;

   always_comb begin
      prod_next = prod_type'(prod_ff + 3'd1);
      first_ops = operands(P_NSXX, queue.head);
      next_ops  = operands(prod_next, snap_ff);
      prod_ext  = NUM_W'(mul_product);
      pop       = (state_ff == B_IDLE) && queue.valid;
   end

   lsf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .opd_a   (mul_a_ff),
      .opd_b   (mul_b_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   lsf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_ff),
      .num   (div_num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         mul_start_ff  <= 1'b0;
         div_start_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         mul_start_ff  <= 1'b0;
         div_start_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            B_IDLE: begin
               if (queue.valid) begin
                  snap_ff      <= queue.head;
                  prod_ff      <= P_NSXX;
                  mul_a_ff     <= first_ops.a;
                  mul_b_ff     <= first_ops.b;
                  mul_start_ff <= 1'b1;
                  den_ff       <= '0;
                  sn_ff        <= '0;
                  in_ff        <= '0;
                  state_ff     <= B_MUL;
               end
            end
            B_MUL: begin
               if (mul_done) begin
                  case (prod_ff)
                     P_NSXX:  den_ff <= den_ff + prod_ext;
                     P_SXSX:  den_ff <= den_ff - prod_ext;
                     P_NSXY:  sn_ff  <= sn_ff + prod_ext;
                     P_SXSY:  sn_ff  <= sn_ff - prod_ext;
                     P_SYSXX: in_ff  <= in_ff + prod_ext;
                     P_SXSXY: in_ff  <= in_ff - prod_ext;
                     default: ;
                  endcase
                  if (prod_ff == P_SXSXY) begin
                     state_ff <= B_CHECK;
                  end else begin
                     prod_ff      <= prod_next;
                     mul_a_ff     <= next_ops.a;
                     mul_b_ff     <= next_ops.b;
                     mul_start_ff <= 1'b1;
                  end
               end
            end
            B_CHECK: begin
               if (den_ff[NUM_W-1] || den_ff == '0) begin
                  rsp_slope_ff      <= '0;
                  rsp_intercept_ff  <= '0;
                  rsp_degenerate_ff <= 1'b1;
                  rsp_strobe_ff     <= 1'b1;
                  state_ff          <= B_IDLE;
               end else begin
                  div_num_ff   <= sn_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= B_DIV_S;
               end
            end
            B_DIV_S: begin
               if (div_done) begin
                  rsp_slope_ff <= div_quot;
                  div_num_ff   <= in_ff;
                  div_start_ff <= 1'b1;
                  state_ff     <= B_DIV_I;
               end
            end
            B_DIV_I: begin
               if (div_done) begin
                  rsp_intercept_ff  <= div_quot;
                  rsp_degenerate_ff <= 1'b0;
                  rsp_strobe_ff     <= 1'b1;
                  state_ff          <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_slope      = rsp_slope_ff;
   assign rsp_intercept  = rsp_intercept_ff;
   assign rsp_degenerate = rsp_degenerate_ff;

endmodule
`default_nettype wire

// File: hw/rtl/least_squares_line_fit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Least-squares line fit
// Streams signed (x, y) sample pairs and returns slope and intercept of the
// least-squares line in fixed point with FRAC_BITS fraction bits.
//
// Input: a sample beat is taken on a rising edge with start high and busy
// low. One pair per cycle is taken back to back while busy stays low. A set
// closes on the pair with req_last_sample high, or on the MAX_SAMPLES-th
// pair of the set. Closed sets wait in a two-entry queue; busy is high
// while it is full. Output: one result per closed set, shown for one cycle
// with rsp_strobe high. The receiver cannot stall, so nothing is held back
// on this side. Results are formed on the shared shift-add multiplier (one
// operand bit a cycle, six products) and the shared restoring divider (one
// quotient bit a cycle, two quotients). A degenerate set skips the divider.
// The engine pops the next waiting set, if any, while rsp_strobe is high.
// Reset clears the running sums, the queue and the engine; no item is
// taken in the cycle of reset.
// ----------------------------------------------------------------------------
module least_squares_line_fit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [lsf_pkg::X_W-1:0] req_x_sample,
   input  wire logic signed [lsf_pkg::X_W-1:0] req_y_sample,
   input  wire logic                          req_last_sample,
   output logic                               rsp_strobe,
   output logic signed [lsf_pkg::OUT_W-1:0]   rsp_slope,
   output logic signed [lsf_pkg::OUT_W-1:0]   rsp_intercept,
   output logic                               rsp_degenerate
);
   import lsf_pkg::*;

   push_type         push;
   queue_status_type queue_status;
   logic             pop;

   lsf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_x_sample    (req_x_sample),
      .req_y_sample    (req_y_sample),
      .req_last_sample (req_last_sample),
      .queue_full      (queue_status.full),
      .push            (push)
   );

   lsf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (queue_status)
   );

   lsf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue          (queue_status),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_slope      (rsp_slope),
      .rsp_intercept  (rsp_intercept),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule
`default_nettype wire

// File: dv/line_fit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line fit checker
// Watches the sample and result channels of the least-squares line fit.
// It keeps exact running sums of every accepted sample beat and solves each
// closed set in wide signed arithmetic. That gives the expected slope,
// intercept and degenerate flag, which are queued. Each result strobe is
// compared field by field with the oldest queued fit. It reports the number
// of fits still awaited and the number of failures seen so far.
// ----------------------------------------------------------------------------
module line_fit_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic signed [lsf_pkg::X_W-1:0]  req_x_sample,
   input  wire logic signed [lsf_pkg::X_W-1:0]  req_y_sample,
   input  wire logic                            req_last_sample,
   input  wire logic                            rsp_strobe,
   input  wire logic signed [lsf_pkg::OUT_W-1:0] rsp_slope,
   input  wire logic signed [lsf_pkg::OUT_W-1:0] rsp_intercept,
   input  wire logic                            rsp_degenerate,
   output int                                   outstanding,
   output int                                   failures
);
   import lsf_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef logic signed [159:0] wide_type;

   typedef struct {
      logic signed [OUT_W-1:0] slope;
      logic signed [OUT_W-1:0] intercept;
      logic                    degenerate;
   } fit_type;

   localparam wide_type DEN_CEIL = wide_type'(1) <<< 63;
   localparam wide_type POS_SAT  = (wide_type'(1) <<< (OUT_W - 1)) - 1;
   localparam wide_type NEG_SAT  = -(wide_type'(1) <<< (OUT_W - 1));

   wide_type sum_xy;
   wide_type sum_x;
   wide_type sum_y;
   wide_type sum_xx;
   int       pair_count;
   wide_type x_wide;
   wide_type y_wide;
   int       mismatch_count = 0;
   fit_type  expected_fits[$];
   fit_type  want;

   initial begin
      outstanding = 0;
      failures    = 0;
   end

   function automatic logic signed [OUT_W-1:0] fixed_quotient(wide_type num, wide_type den);
      wide_type q;
      q = (num <<< FRAC_BITS) / den;
      if (q > POS_SAT)
         q = POS_SAT;
      else if (q < NEG_SAT)
         q = NEG_SAT;
      return q[OUT_W-1:0];
   endfunction

   function automatic fit_type solve_fit(wide_type n, wide_type sxy, wide_type sx,
                                         wide_type sy, wide_type sxx);
      wide_type den;
      fit_type  fit;
      den            = n * sxx - sx * sx;
      fit.slope      = '0;
      fit.intercept  = '0;
      fit.degenerate = 1'b0;
      if (den <= 0 || den >= DEN_CEIL) begin
         fit.degenerate = 1'b1;
         return fit;
      end
      fit.slope     = fixed_quotient(n * sxy - sx * sy, den);
      fit.intercept = fixed_quotient(sy * sxx - sx * sxy, den);
      return fit;
   endfunction

   task automatic log_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sum_xy     = '0;
         sum_x      = '0;
         sum_y      = '0;
         sum_xx     = '0;
         pair_count = 0;
         expected_fits.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_fits.size() == 0) begin
               log_failure($sformatf("unexpected fit: slope %0d intercept %0d degenerate %0b",
                                     rsp_slope, rsp_intercept, rsp_degenerate));
            end else begin
               want = expected_fits.pop_front();
               if (rsp_slope !== want.slope || rsp_intercept !== want.intercept ||
                   rsp_degenerate !== want.degenerate)
                  log_failure($sformatf({"fit mismatch: slope %0d/%0d intercept %0d/%0d ",
                                         "degenerate %0b/%0b (expected/actual)"},
                                        want.slope, rsp_slope, want.intercept,
                                        rsp_intercept, want.degenerate, rsp_degenerate));
            end
         end
         if (start && !busy) begin
            x_wide = wide_type'(req_x_sample);
            y_wide = wide_type'(req_y_sample);
            sum_xy += x_wide * y_wide;
            sum_x  += x_wide;
            sum_y  += y_wide;
            sum_xx += x_wide * x_wide;
            pair_count++;
            if (req_last_sample || pair_count == MAX_SAMPLES) begin
               expected_fits.push_back(solve_fit(wide_type'(pair_count), sum_xy, sum_x,
                                                 sum_y, sum_xx));
               sum_xy     = '0;
               sum_x      = '0;
               sum_y      = '0;
               sum_xx     = '0;
               pair_count = 0;
            end
         end
      end
      outstanding <= expected_fits.size();
      failures    <= mismatch_count;
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-squares line fit testbench
// Drives sample beats into the line fit block: a directed run of edge
// cases, then sets of random pairs under three idle patterns, including a
// set long enough to close on the sample limit. A checker beside the block
// predicts and compares every fit. The top waits for all fits and prints
// the verdict.
// ----------------------------------------------------------------------------
module tb;
   import lsf_pkg::*;

   localparam int FIT_LATENCY = 6 * (OPD_W + 3) + 2 * (DVD_W + 3) + 2;
   localparam int ITEM_BUDGET = 1400;
   localparam int CYCLE_LIMIT = 4 * ITEM_BUDGET * (FIT_LATENCY + 20);
   localparam int PHASE_ITEMS = 110;

   localparam logic signed [X_W-1:0] X_MIN = X_W'(-(2 ** (X_W - 1)));
   localparam logic signed [X_W-1:0] X_MAX = X_W'(2 ** (X_W - 1) - 1);

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [X_W-1:0]   req_x_sample;
   logic signed [X_W-1:0]   req_y_sample;
   logic                    req_last_sample;
   logic                    rsp_strobe;
   logic signed [OUT_W-1:0] rsp_slope;
   logic signed [OUT_W-1:0] rsp_intercept;
   logic                    rsp_degenerate;
   int                      outstanding;
   int                      failures;
   int                      idle_pct = 0;
   int                      cycle_count = 0;

   always #2 clock = ~clock;

   least_squares_line_fit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_x_sample    (req_x_sample),
      .req_y_sample    (req_y_sample),
      .req_last_sample (req_last_sample),
      .rsp_strobe      (rsp_strobe),
      .rsp_slope       (rsp_slope),
      .rsp_intercept   (rsp_intercept),
      .rsp_degenerate  (rsp_degenerate)
   );

   line_fit_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_x_sample    (req_x_sample),
      .req_y_sample    (req_y_sample),
      .req_last_sample (req_last_sample),
      .rsp_strobe      (rsp_strobe),
      .rsp_slope       (rsp_slope),
      .rsp_intercept   (rsp_intercept),
      .rsp_degenerate  (rsp_degenerate),
      .outstanding     (outstanding),
      .failures        (failures)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic signed [X_W-1:0] pick_sample();
      case ($urandom_range(9))
         0: return X_MIN;
         1: return X_MAX;
         2: return '0;
         3: return X_W'(int'($urandom_range(8)) - 4);
         default: return X_W'($urandom);
      endcase
   endfunction

   // hold the beat until accepted; idle at random before it
   task automatic send_pair(input logic signed [X_W-1:0] x, input logic signed [X_W-1:0] y,
                            input logic last);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_x_sample    <= x;
      req_y_sample    <= y;
      req_last_sample <= last;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_set(input int size, input bit mark_last);
      logic signed [X_W-1:0] x_base;
      logic signed [X_W-1:0] x;
      int                    x_mode;
      x_mode = $urandom_range(7);
      x_base = pick_sample();
      for (int i = 0; i < size; i++) begin
         if (x_mode == 0)
            x = x_base;
         else if (x_mode == 1)
            x = x_base + X_W'($urandom_range(3));
         else
            x = pick_sample();
         send_pair(x, pick_sample(), mark_last && i == size - 1);
      end
   endtask

   task automatic send_random_sets(input int item_count);
      int sent;
      int size;
      sent = 0;
      while (sent < item_count) begin
         size = ($urandom_range(3) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         send_set(size, 1'b1);
         sent += size;
      end
   endtask

   // drop start and hold off until every fit has come back
   task automatic wait_for_fits();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_x_sample    <= '0;
      req_y_sample    <= '0;
      req_last_sample <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 8;
      send_pair(X_MIN, X_MAX, 1'b1);
      send_pair(X_MAX, X_MIN, 1'b1);
      send_pair('0, X_W'(5), 1'b0);
      send_pair('0, X_W'(-7), 1'b1);
      send_pair(X_W'(X_MAX - 1), X_MIN, 1'b0);
      send_pair(X_MAX, X_MAX, 1'b1);
      send_pair(X_MIN, X_MAX, 1'b0);
      send_pair(X_W'(X_MIN + 1), X_MIN, 1'b1);
      send_pair(X_MIN, X_MIN, 1'b0);
      send_pair(X_MAX, X_MAX, 1'b1);
      send_pair(X_W'(-1), X_W'(-1), 1'b0);
      send_pair('0, '0, 1'b0);
      send_pair(X_W'(1), X_W'(1), 1'b1);
      send_pair(X_W'(1), '0, 1'b0);
      send_pair(X_W'(2), X_W'(1), 1'b0);
      send_pair(X_W'(4), X_W'(-3), 1'b1);
      send_pair(X_MIN, '0, 1'b0);
      send_pair(X_MAX, X_MIN, 1'b0);
      send_pair('0, X_MAX, 1'b0);
      send_pair(X_W'(100), X_W'(-100), 1'b1);
      wait_for_fits();

      send_random_sets(PHASE_ITEMS);
      wait_for_fits();

      idle_pct = 60;
      send_random_sets(PHASE_ITEMS);
      wait_for_fits();

      idle_pct = 0;
      send_set(MAX_SAMPLES, 1'b0);
      send_random_sets(PHASE_ITEMS);
      wait_for_fits();

      repeat (FIT_LATENCY + 20) @(posedge clock);
      if (failures == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
